// ===== rtl/core/kti_pkg.sv =====
// shared types and constants for the keyframe track interpolator
// no dependencies
package kti_pkg;

  localparam int unsigned ChanW = 32;
  localparam int unsigned NumChan = 8;
  localparam int unsigned WeightOne = 32'd65536;

  localparam logic [1:0] ActClear  = 2'd0;
  localparam logic [1:0] ActAppend = 2'd1;
  localparam logic [1:0] ActStart  = 2'd2;
  localparam logic [1:0] ActStep   = 2'd3;

  localparam logic [1:0] StIdle     = 2'd0;
  localparam logic [1:0] StPlaying  = 2'd1;
  localparam logic [1:0] StFinished = 2'd2;
  localparam logic [1:0] StArmed    = 2'd3;
  localparam logic [1:0] StatusError = 2'd3;

  // one keyframe row: time then the eight channels, colour last
  typedef struct packed {
    logic [31:0]            t;
    logic [NumChan-1:0][31:0] ch;
  } key_t;

  typedef enum logic [2:0] {
    DpNone,
    DpWrite,   // write request row at key_count
    DpRead,    // issue memory read at rd index
    DpHold,    // copy read row to held frame
    DpLoadA,   // latch read row as segment start
    DpDivGo,   // start weight division
    DpBlend,   // run blend sweep
    DpSetTime  // held time = request time
  } dp_op_t;

  typedef struct packed {
    dp_op_t      op;
    logic [10:0] rd_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [31:0] rd_time;  // time of the row read last
    logic        div_done;
    logic        blend_done;
  } dp_stat_t;

endpackage

// ===== rtl/core/kti_datapath.sv =====
// keyframe memory, weight divider, blend unit and held frame
// depends on kti_pkg
module kti_datapath #(
  parameter int unsigned MAX_KEYS = 64,
  parameter int unsigned IdxW = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  kti_pkg::dp_cmd_t    cmd,
  input  logic [IdxW-1:0]     wr_idx,
  input  kti_pkg::key_t       req_key,
  input  logic [31:0]         req_time,
  output kti_pkg::dp_stat_t   stat,
  output kti_pkg::key_t       held
);

  kti_pkg::key_t mem [MAX_KEYS];
  kti_pkg::key_t rd_row;
  kti_pkg::key_t row_a;

  always_ff @(posedge clk) begin
    if (cmd.op == kti_pkg::DpWrite) begin
      mem[wr_idx] <= req_key;
    end
    rd_row <= mem[cmd.rd_idx[IdxW-1:0]];
  end

  assign stat.rd_time = rd_row.t;

  // restoring divider: ((t1 - t) << 16) / (t1 - t0), quotient <= 65536
  logic [48:0] num;
  logic [31:0] den;
  logic [31:0] rem;
  logic [16:0] quo;
  logic [5:0]  div_cnt;
  logic        div_busy;
  logic [32:0] rem_sh;
  logic [33:0] rem_sub;

  assign rem_sh  = {rem, num[48]};
  assign rem_sub = {1'b0, rem_sh} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (cmd.op == kti_pkg::DpDivGo) begin
      div_busy <= 1'b1;
      div_cnt  <= 6'd49;
      num      <= {1'b0, (rd_row.t - req_time), 16'd0};
      den      <= rd_row.t - row_a.t;
      rem      <= '0;
      quo      <= '0;
    end else if (div_busy) begin
      num <= {num[47:0], 1'b0};
      if (!rem_sub[33]) begin
        rem <= rem_sub[31:0];
        quo <= {quo[15:0], 1'b1};
      end else begin
        rem <= rem_sh[31:0];
        quo <= {quo[15:0], 1'b0};
      end
      div_cnt <= div_cnt - 6'd1;
      if (div_cnt == 6'd1) begin
        div_busy <= 1'b0;
      end
    end
  end

  assign stat.div_done = !div_busy && (cmd.op != kti_pkg::DpDivGo);

  // blend sweep: one channel per cycle, one 33x18 multiply pair
  logic [2:0]  bl_cnt;
  logic        bl_busy;
  logic [2:0]  ch_sel;
  logic signed [17:0] w0;
  logic signed [17:0] w1;
  logic [31:0] a_v;
  logic [31:0] b_v;
  logic signed [32:0] a_s;
  logic signed [32:0] b_s;
  logic signed [50:0] prod_a;
  logic signed [50:0] prod_b;
  logic signed [51:0] sum_s;
  logic [31:0] res_s;
  logic [31:0] res_c;
  logic [25:0] csum;

  assign ch_sel = bl_cnt;
  assign w0 = {1'b0, quo};
  assign w1 = 18'sd65536 - w0;
  assign a_v = row_a.ch[ch_sel];
  assign b_v = rd_row.ch[ch_sel];
  assign a_s = {a_v[31], a_v};
  assign b_s = {b_v[31], b_v};
  assign prod_a = a_s * w0;
  assign prod_b = b_s * w1;
  assign sum_s = 52'(prod_a) + 52'(prod_b) + 52'sd32768;
  assign res_s = sum_s[47:16];

  always_comb begin
    res_c = '0;
    for (int i = 0; i < 4; i++) begin
      csum = ({18'd0, a_v[i*8 +: 8]} * {9'd0, quo})
           + ({18'd0, b_v[i*8 +: 8]} * {9'd0, w1[16:0]}) + 26'd32768;
      res_c[i*8 +: 8] = csum[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bl_busy <= 1'b0;
      bl_cnt  <= '0;
      held    <= '0;
    end else begin
      if (cmd.op == kti_pkg::DpLoadA) begin
        row_a <= rd_row;
      end
      if (cmd.op == kti_pkg::DpHold) begin
        held <= rd_row;
      end
      if (cmd.op == kti_pkg::DpSetTime) begin
        held.t <= req_time;
      end
      if (cmd.op == kti_pkg::DpBlend && !bl_busy) begin
        bl_busy <= 1'b1;
        bl_cnt  <= '0;
      end else if (bl_busy) begin
        // colour is the last channel
        held.ch[ch_sel] <= (ch_sel == 3'(kti_pkg::NumChan - 1)) ? res_c : res_s;
        bl_cnt <= bl_cnt + 3'd1;
        if (ch_sel == 3'(kti_pkg::NumChan - 1)) begin
          bl_busy <= 1'b0;
        end
      end
    end
  end

  assign stat.blend_done = !bl_busy && (cmd.op != kti_pkg::DpBlend);

endmodule

// ===== rtl/core/kti_control.sv =====
// playback controller: action decode, segment search, sequencing
// depends on kti_pkg
module kti_control #(
  parameter int unsigned MAX_KEYS = 64,
  parameter int unsigned IdxW = 6,
  parameter int unsigned CntW = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        action,
  input  logic [31:0]       time_value,
  output logic              busy,
  output logic              done,
  output logic [1:0]        status,
  output logic [31:0]       req_time,
  output logic [IdxW-1:0]   wr_idx,
  output kti_pkg::dp_cmd_t  cmd,
  input  kti_pkg::dp_stat_t stat
);

  typedef enum logic [3:0] {
    SIdle, SHoldRd, SHoldWt, SHoldCp, SLastRd, SLastWt, SSrchRd, SSrchWt,
    SDiv, SDivWt, SBlend, SBlendWt, SDone
  } state_t;

  state_t      state;
  logic [1:0]  play;
  logic [CntW-1:0] key_count;
  logic [10:0] idx;
  logic [31:0] t0_prev;
  logic        finish_after;
  logic [1:0]  status_q;

  logic [10:0] last;
  assign last = 11'(key_count) - 11'd1;
  assign busy = (state != SIdle);
  assign wr_idx = key_count[IdxW-1:0];

  always_comb begin
    cmd.op = kti_pkg::DpNone;
    cmd.rd_idx = idx;
    case (state)
      SIdle: begin
        if (start && action == kti_pkg::ActAppend && 32'(key_count) < MAX_KEYS) begin
          cmd.op = kti_pkg::DpWrite;
        end
      end
      SHoldCp:  cmd.op = kti_pkg::DpHold;
      SDiv:     cmd.op = kti_pkg::DpDivGo;
      SBlend:   cmd.op = kti_pkg::DpBlend;
      SSrchWt: begin
        // keep segment start so the blend sees key n and key n+1
        if (idx != 11'd0 && t0_prev <= req_time && req_time < stat.rd_time) begin
          cmd.op = kti_pkg::DpSetTime;
        end else begin
          cmd.op = kti_pkg::DpLoadA;
        end
      end
      default: cmd.op = kti_pkg::DpNone;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SIdle;
      play      <= kti_pkg::StIdle;
      key_count <= '0;
      done      <= 1'b0;
      status    <= kti_pkg::StIdle;
      idx       <= '0;
      status_q  <= kti_pkg::StIdle;
      finish_after <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        SIdle: begin
          if (start) begin
            req_time <= time_value;
            case (action)
              kti_pkg::ActClear: begin
                key_count <= '0;
                play <= kti_pkg::StIdle;
                status_q <= kti_pkg::StIdle;
                state <= SDone;
              end
              kti_pkg::ActAppend: begin
                if (32'(key_count) < MAX_KEYS) key_count <= key_count + 1'b1;
                status_q <= (play == kti_pkg::StArmed) ? kti_pkg::StPlaying : play;
                state <= SDone;
              end
              kti_pkg::ActStart: begin
                if (key_count < CntW'(2)) begin
                  play <= kti_pkg::StIdle;
                  status_q <= kti_pkg::StatusError;
                end else begin
                  play <= kti_pkg::StArmed;
                  status_q <= kti_pkg::StPlaying;
                end
                state <= SDone;
              end
              default: begin
                if (play == kti_pkg::StArmed) begin
                  play <= kti_pkg::StPlaying;
                  status_q <= kti_pkg::StPlaying;
                  idx <= '0;
                  state <= SHoldRd;
                end else if (play == kti_pkg::StPlaying && key_count >= CntW'(2)) begin
                  idx <= last;
                  status_q <= kti_pkg::StPlaying;
                  state <= SLastRd;
                end else begin
                  status_q <= play;
                  state <= SDone;
                end
              end
            endcase
          end
        end
        SHoldRd: state <= SHoldWt;
        SHoldWt: state <= SHoldCp;
        SHoldCp: begin
          if (finish_after) begin
            play <= kti_pkg::StFinished;
            status_q <= kti_pkg::StFinished;
          end
          finish_after <= 1'b0;
          state <= SDone;
        end
        SLastRd: state <= SLastWt;
        SLastWt: begin
          if (stat.rd_time <= req_time) begin
            finish_after <= 1'b1;
            state <= SHoldCp;
          end else begin
            idx <= '0;
            state <= SSrchRd;
          end
        end
        SSrchRd: state <= SSrchWt;
        SSrchWt: begin
          if (idx != 11'd0 && t0_prev <= req_time && req_time < stat.rd_time) begin
            state <= SDiv;
          end else if (idx == last) begin
            idx <= '0;
            state <= SHoldRd;
          end else begin
            t0_prev <= stat.rd_time;
            idx <= idx + 11'd1;
            state <= SSrchRd;
          end
        end
        SDiv:     state <= SDivWt;
        SDivWt:   if (stat.div_done) state <= SBlend;
        SBlend:   state <= SBlendWt;
        SBlendWt: if (stat.blend_done) state <= SDone;
        SDone: begin
          done <= 1'b1;
          status <= status_q;
          state <= SIdle;
        end
        default: state <= SIdle;
      endcase
    end
  end

endmodule

// ===== rtl/core/keyframe_track_interpolator.sv =====
// keyframe track interpolator: top level
// depends on kti_pkg, kti_control, kti_datapath
//
// one command channel: start with action and fields is taken when busy is
// low. every request yields exactly one result, marked by done for a single
// cycle; the receiver cannot stall it.
// clear, append, start and idle steps go from idle straight to the done
// state. the first step after start holds key 0. a later playing step reads
// the last key and, at or past its time, holds it and finishes; else it
// searches the key memory over its one read port, one row at a time, holds
// key 0 if no segment fits, or runs a restoring divider for the Q1.16
// weight and a blend of the eight channels, one channel per cycle, on one
// multiply pair for the signed channels and byte-lane multipliers for colour.
// reset clears key count, play state and the held frame; key memory
// contents are undefined until appended.
module keyframe_track_interpolator #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [31:0] time_value,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] scale_x,
  input  logic signed [31:0] scale_y,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] rotation,
  input  logic [31:0] color_rgba,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] out_time,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_scale_x,
  output logic signed [31:0] out_scale_y,
  output logic signed [31:0] out_center_x,
  output logic signed [31:0] out_center_y,
  output logic signed [31:0] out_rotation,
  output logic [31:0] out_color_rgba
);

  localparam int unsigned IdxW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned CntW = $clog2(MAX_KEYS + 1);

  kti_pkg::dp_cmd_t  cmd;
  kti_pkg::dp_stat_t stat;
  kti_pkg::key_t     req_key;
  kti_pkg::key_t     held;
  logic [31:0]       req_time;
  logic [IdxW-1:0]   wr_idx;

  assign req_key.t = time_value;
  assign req_key.ch[0] = pos_x;
  assign req_key.ch[1] = pos_y;
  assign req_key.ch[2] = scale_x;
  assign req_key.ch[3] = scale_y;
  assign req_key.ch[4] = center_x;
  assign req_key.ch[5] = center_y;
  assign req_key.ch[6] = rotation;
  assign req_key.ch[7] = color_rgba;

  kti_control #(.MAX_KEYS(MAX_KEYS), .IdxW(IdxW), .CntW(CntW)) u_ctrl (
    .clk, .rst, .start, .action, .time_value, .busy, .done, .status,
    .req_time, .wr_idx, .cmd, .stat
  );

  kti_datapath #(.MAX_KEYS(MAX_KEYS), .IdxW(IdxW)) u_dp (
    .clk, .rst, .cmd, .wr_idx, .req_key, .req_time, .stat, .held
  );

  assign out_time       = held.t;
  assign out_pos_x      = held.ch[0];
  assign out_pos_y      = held.ch[1];
  assign out_scale_x    = held.ch[2];
  assign out_scale_y    = held.ch[3];
  assign out_center_x   = held.ch[4];
  assign out_center_y   = held.ch[5];
  assign out_rotation   = held.ch[6];
  assign out_color_rgba = held.ch[7];

endmodule
